@@ src/uartrb_pkg.sv @@
// Shared codes, widths and types of the serial console ring buffers.
package uartrb_pkg;

  // Width of the message length and fill count fields.
  localparam int unsigned LEN_W = 13;

  // Operation codes of an input transaction.
  localparam logic [2:0] OP_RX_BYTE  = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_ERASE    = 3'd2;
  localparam logic [2:0] OP_TX_REQ   = 3'd3;
  localparam logic [2:0] OP_TX_BYTE  = 3'd4;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RETRY    = 3'd2;
  localparam logic [2:0] ST_NEVER    = 3'd3;
  localparam logic [2:0] ST_NO_RSV   = 3'd4;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } seq_state_t;

endpackage

@@ src/uart_rx_tx_ring_buffers.sv @@
// Receive and transmit byte ring buffers of a serial console, memory based.
//
// An input transaction runs as follows: in the accept cycle the
// receive and transmit memories are read (one synchronous read port each),
// and in the execute state the operation and the send tick are resolved,
// the memories are written back and the result is loaded into the output
// register. The next transaction is accepted in the cycle after that, even
// while the previous result still waits in the output register; a result
// that cannot be loaded because the output register is still occupied holds
// the block until the output side takes the waiting transaction. No clearing
// pass runs after reset: buffer entries are only read after they were written.
module uart_rx_tx_ring_buffers #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: break character.
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_wdata,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 op,
  input  logic [7:0]                 data,
  input  logic [uartrb_pkg::LEN_W-1:0] msg_len,
  input  logic                       uart_ready,
  // Output channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic [7:0]                 read_byte,
  output logic                       send_valid,
  output logic [7:0]                 send_byte,
  output logic                       break_seen,
  output logic                       tx_irq_enable,
  output logic [uartrb_pkg::LEN_W-1:0] rx_fill,
  output logic [uartrb_pkg::LEN_W-1:0] tx_fill
);

  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned LEN_W = uartrb_pkg::LEN_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

  // Control state.
  uartrb_pkg::seq_state_t state, state_next;
  logic [7:0]       break_char;
  logic [PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic [PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [CNT_W-1:0] tx_count, tx_count_next, tx_rsv, tx_rsv_next;

  // Captured transaction.
  logic [2:0]       op_q;
  logic [7:0]       data_q;
  logic [LEN_W-1:0] len_q;
  logic             ready_q;

  // Memories and their ports.
  logic [7:0]       rx_mem [BUFFER_DEPTH];
  logic [7:0]       tx_mem [BUFFER_DEPTH];
  logic [PTR_W-1:0] rx_raddr, rx_waddr, tx_waddr;
  logic [7:0]       rx_rdata, tx_rdata, rx_wdata;
  logic             rx_we, tx_we;

  // Result computed in the execute cycle.
  logic [2:0]       res_status;
  logic [7:0]       res_rbyte, res_sbyte;
  logic             res_svalid, res_brk;
  logic [CNT_W-1:0] tx_count_mid, tx_rsv_mid;
  logic             tx_wrote;
  logic             accept, finish;

  // Slot arithmetic of a ring that need not be a power of two.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_SLOT : p - PTR_W'(1);
  endfunction

  assign in_ready = !rst && (state == uartrb_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == uartrb_pkg::S_EXEC) && (!out_valid || out_ready);

  // Erase reads the slot before the tail; every other read uses the head.
  assign rx_raddr = (op == uartrb_pkg::OP_ERASE) ? prev_slot(rx_tail) : rx_head;

  // Receive memory: read on accept, write back when the transaction finishes.
  always_ff @(posedge clk) begin
    if (accept) begin
      rx_rdata <= rx_mem[rx_raddr];
    end
    if (rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
  end

  // Transmit memory: the send tick always reads at the head.
  always_ff @(posedge clk) begin
    if (accept) begin
      tx_rdata <= tx_mem[tx_head];
    end
    if (tx_we) begin
      tx_mem[tx_waddr] <= data_q;
    end
  end

  // Capture the transaction payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      data_q  <= data;
      len_q   <= msg_len;
      ready_q <= uart_ready;
    end
  end

  // Operation and send tick, resolved in the execute cycle.
  always_comb begin
    res_status    = uartrb_pkg::ST_OK;
    res_rbyte     = '0;
    res_brk       = 1'b0;
    rx_head_next  = rx_head;
    rx_tail_next  = rx_tail;
    rx_count_next = rx_count;
    rx_we         = 1'b0;
    rx_waddr      = rx_tail;
    rx_wdata      = data_q;
    tx_tail_next  = tx_tail;
    tx_count_mid  = tx_count;
    tx_rsv_mid    = tx_rsv;
    tx_we         = 1'b0;
    tx_waddr      = tx_tail;
    tx_wrote      = 1'b0;
    if (state == uartrb_pkg::S_EXEC) begin
      unique case (op_q)
        uartrb_pkg::OP_RX_BYTE: begin
          rx_we   = finish;
          res_brk = (data_q == break_char);
          if (rx_count != DEPTH_CNT) begin
            rx_tail_next  = next_slot(rx_tail);
            rx_count_next = rx_count + CNT_W'(1);
          end
        end
        uartrb_pkg::OP_READ: begin
          if (rx_count == '0) begin
            res_status = uartrb_pkg::ST_EMPTY;
          end else begin
            res_rbyte     = rx_rdata;
            rx_head_next  = next_slot(rx_head);
            rx_count_next = rx_count - CNT_W'(1);
          end
        end
        uartrb_pkg::OP_ERASE: begin
          if (rx_count == '0) begin
            res_status = uartrb_pkg::ST_EMPTY;
          end else begin
            res_rbyte     = rx_rdata;
            rx_tail_next  = prev_slot(rx_tail);
            rx_count_next = rx_count - CNT_W'(1);
            rx_we         = finish;
            rx_waddr      = prev_slot(rx_tail);
            rx_wdata      = '0;
          end
        end
        uartrb_pkg::OP_TX_REQ: begin
          if (len_q > DEPTH_LEN) begin
            res_status = uartrb_pkg::ST_NEVER;
          end else if (tx_rsv != '0 || len_q > LEN_W'(DEPTH_CNT - tx_count)) begin
            res_status = uartrb_pkg::ST_RETRY;
          end else begin
            tx_rsv_mid   = CNT_W'(len_q);
            tx_count_mid = tx_count + CNT_W'(len_q);
          end
        end
        uartrb_pkg::OP_TX_BYTE: begin
          if (tx_rsv == '0) begin
            res_status = uartrb_pkg::ST_NO_RSV;
          end else begin
            tx_we        = finish;
            tx_wrote     = 1'b1;
            tx_tail_next = next_slot(tx_tail);
            tx_rsv_mid   = tx_rsv - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // Send tick: only written bytes leave; a byte written by this very
    // transaction at the head is forwarded around the memory.
    res_svalid    = ready_q && (tx_count_mid > tx_rsv_mid);
    res_sbyte     = '0;
    tx_head_next  = tx_head;
    tx_count_next = tx_count_mid;
    tx_rsv_next   = tx_rsv_mid;
    if (res_svalid) begin
      res_sbyte     = (tx_wrote && tx_head == tx_tail) ? data_q : tx_rdata;
      tx_head_next  = next_slot(tx_head);
      tx_count_next = tx_count_mid - CNT_W'(1);
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      uartrb_pkg::S_IDLE: if (accept) state_next = uartrb_pkg::S_EXEC;
      uartrb_pkg::S_EXEC: if (finish) state_next = uartrb_pkg::S_IDLE;
      default:            state_next = uartrb_pkg::S_IDLE;
    endcase
  end

  // Control registers; the ring state is updated when the transaction finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= uartrb_pkg::S_IDLE;
      break_char <= 8'd3;
      rx_head    <= '0;
      rx_tail    <= '0;
      rx_count   <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      tx_count   <= '0;
      tx_rsv     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        break_char <= cfg_wdata;
      end
      if (finish) begin
        rx_head   <= rx_head_next;
        rx_tail   <= rx_tail_next;
        rx_count  <= rx_count_next;
        tx_head   <= tx_head_next;
        tx_tail   <= tx_tail_next;
        tx_count  <= tx_count_next;
        tx_rsv    <= tx_rsv_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (finish) begin
      status        <= res_status;
      read_byte     <= res_rbyte;
      send_valid    <= res_svalid;
      send_byte     <= res_sbyte;
      break_seen    <= res_brk;
      tx_irq_enable <= (tx_count_next != '0);
      rx_fill       <= LEN_W'(rx_count_next);
      tx_fill       <= LEN_W'(tx_count_next);
    end
  end

`ifndef ASSERT_OFF
  // The receive ring never holds more bytes than it has slots.
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= DEPTH_CNT)
    else $error("receive count exceeds depth");

  // Reserved room is always part of the transmit count.
  a_rsv_bound: assert property (@(posedge clk) disable iff (rst)
    tx_rsv <= tx_count && tx_count <= DEPTH_CNT)
    else $error("transmit reservation exceeds count");

  // An accepted transaction blocks the input until it has finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  // A result held up by a full output register keeps the block busy.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == uartrb_pkg::S_EXEC && out_valid && !out_ready) |=>
      (state == uartrb_pkg::S_EXEC && out_valid))
    else $error("result lost while output was stalled");
`endif

endmodule
